FILE: rtl/core/sktl_pkg.sv
`default_nettype none

package sktl_pkg;

	localparam int TABLE_DEPTH = 32768;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = 16;
	localparam int KEY_W       = 32;
	localparam int DATA_W      = 32;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef struct packed {
		logic              op;
		logic [14:0]       slot;
		logic [KEY_W-1:0]  entry_key;
		logic              entry_present;
		logic              entry_deleted;
		logic [DATA_W-1:0] entry_start;
		logic [DATA_W-1:0] entry_size;
		logic [KEY_W-1:0]  lookup_key;
	} in_t;

	typedef struct packed {
		logic              found;
		logic [DATA_W-1:0] start_position;
		logic [DATA_W-1:0] stored_size;
	} out_t;

	// one table row as held in the ram
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic              deleted;
		logic              present;
		logic [DATA_W-1:0] start;
		logic [DATA_W-1:0] size;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

FILE: rtl/core/sktl_ram.sv
`default_nettype none

module sktl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/sorted_key_table_lookup.sv
// sorted key table with binary search lookup
// input channel in_valid/in_ready carries one word of type in_t. op selects
// a load (write one table row at slot, no result) or a lookup (search the
// first entry_count rows for lookup_key, one result word).
// output channel out_valid/out_ready carries one out_t word per lookup:
// found, start offset and packed size, the last two zero on a miss.
// the user must write entry_count through cfg_we/cfg_wdata only while the
// block is idle; the block itself does not enforce this. counts above the
// table depth are clamped to the depth. a load writes its row on acceptance.
// a lookup reads the middle row on acceptance, then probes one row per read
// of the single-port table ram, whose registered read feeds the compare and
// the next address, until a hit or the last candidate. with 32768 rows that
// is at most 16 probes; an empty table skips them. in_ready is low while
// a lookup is in flight. a finished result sits in the output register; a
// stalled receiver holds it there and a further lookup waits in its final
// cycle until it drains. loads are taken only while no lookup is in flight.
// reset clears the sequencer, the output valid and entry_count. the table
// is not cleared: a lookup must only probe rows loaded since reset.
`default_nettype none

module sorted_key_table_lookup (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [sktl_pkg::CNT_W-1:0]   cfg_wdata,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire sktl_pkg::in_t                in_data,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output sktl_pkg::out_t                    out_data
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_PROBE = 2'd1;
	localparam logic [1:0] S_DONE  = 2'd2;

	logic [1:0]                     state_q;
	logic [sktl_pkg::CNT_W-1:0]     count_q;
	logic [sktl_pkg::CNT_W-1:0]     lo_q;
	logic [sktl_pkg::CNT_W-1:0]     hi_q;
	logic [sktl_pkg::ADDR_W-1:0]    mid_q;
	logic [sktl_pkg::KEY_W-1:0]     key_q;
	sktl_pkg::out_t                 res_q;
	sktl_pkg::out_t                 out_q;
	logic                           out_valid_q;

	logic                           ram_we;
	logic                           ram_re;
	logic [sktl_pkg::ADDR_W-1:0]    ram_addr;
	sktl_pkg::entry_t               ram_wdata;
	sktl_pkg::entry_t               ram_rdata;

	logic                           accept;
	logic                           start_lookup;
	logic [sktl_pkg::CNT_W-1:0]     hi_init;
	logic [sktl_pkg::ADDR_W-1:0]    mid_init;
	logic                           hit;
	logic                           last;
	logic                           go_up;
	logic [sktl_pkg::CNT_W:0]       sum_up;
	logic [sktl_pkg::CNT_W:0]       sum_dn;
	logic [sktl_pkg::ADDR_W-1:0]    mid_next;
	logic                           out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || out_ready;

	// clamp the count to the table depth
	assign hi_init = (32'(count_q) > sktl_pkg::TABLE_DEPTH)
		? sktl_pkg::CNT_W'(sktl_pkg::TABLE_DEPTH) : count_q;
	assign mid_init     = sktl_pkg::ADDR_W'(hi_init >> 1);
	assign start_lookup = accept && (in_data.op == sktl_pkg::OP_LOOKUP) && (hi_init != '0);

	// probe evaluation on the registered row
	assign hit    = (ram_rdata.key == key_q) && ram_rdata.present && !ram_rdata.deleted;
	assign last   = ((lo_q + 1'b1) == hi_q);
	assign go_up  = (key_q >= ram_rdata.key);
	// both candidate midpoints in parallel with the compare
	assign sum_up = {1'b0, sktl_pkg::CNT_W'(mid_q)} + {1'b0, hi_q};
	assign sum_dn = {1'b0, lo_q} + {1'b0, sktl_pkg::CNT_W'(mid_q)};
	assign mid_next = go_up ? sktl_pkg::ADDR_W'(sum_up >> 1)
	                        : sktl_pkg::ADDR_W'(sum_dn >> 1);

	always_comb begin
		ram_we    = accept && (in_data.op == sktl_pkg::OP_LOAD)
			&& (32'(in_data.slot) < sktl_pkg::TABLE_DEPTH);
		ram_re    = 1'b0;
		ram_addr  = sktl_pkg::ADDR_W'(in_data.slot);
		ram_wdata = '{key:     in_data.entry_key,
		              deleted: in_data.entry_deleted,
		              present: in_data.entry_present,
		              start:   in_data.entry_start,
		              size:    in_data.entry_size};
		if (start_lookup) begin
			ram_re   = 1'b1;
			ram_addr = mid_init;
		end else if (state_q == S_PROBE && !hit && !last) begin
			ram_re   = 1'b1;
			ram_addr = mid_next;
		end
	end

	sktl_ram #(
		.WIDTH(sktl_pkg::ENTRY_W),
		.DEPTH(sktl_pkg::TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				count_q <= cfg_wdata;
			end
			// a new result may replace the one draining in the same cycle
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && in_data.op == sktl_pkg::OP_LOOKUP) begin
						state_q <= (hi_init != '0) ? S_PROBE : S_DONE;
					end
				end
				S_PROBE: begin
					if (hit || last) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= in_data.lookup_key;
			lo_q  <= '0;
			hi_q  <= hi_init;
			mid_q <= mid_init;
			res_q <= '0;
		end
		if (state_q == S_PROBE) begin
			if (hit) begin
				res_q <= '{found: 1'b1, start_position: ram_rdata.start,
				          stored_size: ram_rdata.size};
			end else if (!last) begin
				mid_q <= mid_next;
				if (go_up) begin
					lo_q <= sktl_pkg::CNT_W'(mid_q);
				end else begin
					hi_q <= sktl_pkg::CNT_W'(mid_q);
				end
			end
		end
		if (state_q == S_DONE && out_free) begin
			out_q <= res_q;
		end
	end

	a_bounds_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PROBE |-> lo_q < hi_q)
		else $error("search bounds crossed");

	a_mid_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PROBE |->
			sktl_pkg::CNT_W'(mid_q) >= lo_q && sktl_pkg::CNT_W'(mid_q) < hi_q)
		else $error("probe outside search bounds");

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !ram_we)
		else $error("table written during a lookup");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.found |->
			out_data.start_position == '0 && out_data.stored_size == '0)
		else $error("miss word carries nonzero fields");

	a_done_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && out_valid_q && !out_ready |=> state_q == S_DONE)
		else $error("result dropped while output stalled");

endmodule

`default_nettype wire
